>>> src/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants for the min-heap priority queue
// Item structs, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Default number of heap entries
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_OUT_W  = 11;

  typedef logic signed [DATA_W-1:0] data_t;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic  cmd;
    data_t value;
  } in_item_t;

  typedef struct packed {
    data_t                  removed_value;
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_ROOT,
    S_DOWN,
    S_WR,
    S_DONE
  } seq_state_t;

endpackage

>>> src/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram: heap entry store
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module mhpq_ram
  import mhpq_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(CAPACITY_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  data_t         wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output data_t         rd_data_a,
  output data_t         rd_data_b
);

  data_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> src/min_heap_priority_queue.sv
// Insert reads the parent, then climbs in the sift-up state (at most log2(CAPACITY)
// levels) and writes the value; remove reads the root and the last entry, then sinks
// in the sift-down state and writes. One level per cycle, as the store read data is
// registered. A remove that empties the heap writes nothing; rejected commands go to
// done. The next item is taken only after the result is posted, even while it waits.
// Reset clears the entry count and the handshake state; store contents are kept.
// ----------------------------------------------------------------------------
// min_heap_priority_queue: binary min-heap of signed 32-bit values
// Sequencer sifting entries up on insert and down on remove, over a
// dual-read-port store, with an output register on the result channel.
// ----------------------------------------------------------------------------
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;

  seq_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  data_t         moving_r, moving_nxt;
  data_t         res_removed_r, res_removed_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  out_item_t     out_item_r, out_item_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  data_t         wr_data;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  data_t         rd_data_a, rd_data_b;

  logic          in_fire;
  logic          out_free;
  logic          is_full, is_empty;
  logic [AW-1:0] ins_parent, up_parent, up_grand;
  logic          up_stop;
  logic [IW-1:0] m_ext, dn_cl, dn_cr, nx_cl, nx_cr;
  logic          pick_right, dn_stop;
  data_t         dn_sel;
  logic [AW-1:0] dn_cidx;

  mhpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  // Sift-up index math
  assign ins_parent = AW'((count_r - CW'(1)) >> 1);
  assign up_parent  = (pos_r - AW'(1)) >> 1;
  assign up_grand   = (up_parent - AW'(1)) >> 1;
  assign up_stop    = (rd_data_a <= moving_r);

  // Sift-down child selection (left child wins a tie)
  assign m_ext      = IW'(count_r);
  assign dn_cl      = {1'b0, pos_r, 1'b1};
  assign dn_cr      = dn_cl + IW'(1);
  assign pick_right = (dn_cr < m_ext) && (rd_data_b < rd_data_a);
  assign dn_sel     = pick_right ? rd_data_b : rd_data_a;
  assign dn_cidx    = pick_right ? dn_cr[AW-1:0] : dn_cl[AW-1:0];
  assign dn_stop    = (moving_r <= dn_sel);
  assign nx_cl      = {1'b0, dn_cidx, 1'b1};
  assign nx_cr      = nx_cl + IW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_item.cmd == CMD_INSERT) begin
            if (is_full) state_nxt = S_DONE;
            else if (is_empty) state_nxt = S_WR;
            else state_nxt = S_UP;
          end else begin
            state_nxt = is_empty ? S_DONE : S_ROOT;
          end
        end
      end
      S_UP: begin
        if (up_stop) state_nxt = S_DONE;
        else if (up_parent == '0) state_nxt = S_WR;
      end
      S_ROOT: begin
        if (count_r == '0) state_nxt = S_DONE;
        else if (count_r == CW'(1)) state_nxt = S_WR;
        else state_nxt = S_DOWN;
      end
      S_DOWN: begin
        if (dn_stop) state_nxt = S_DONE;
        else if (nx_cl >= m_ext) state_nxt = S_WR;
      end
      S_WR:    state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and store port control
  always_comb begin
    count_nxt       = count_r;
    pos_nxt         = pos_r;
    moving_nxt      = moving_r;
    res_removed_nxt = res_removed_r;
    res_status_nxt  = res_status_r;
    out_item_nxt    = out_item_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    wr_en           = 1'b0;
    wr_addr         = pos_r;
    wr_data         = moving_r;
    rd_addr_a       = '0;
    rd_addr_b       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_removed_nxt = '0;
          res_status_nxt  = ST_DONE;
          if (in_item.cmd == CMD_INSERT) begin
            if (is_full) begin
              res_status_nxt = ST_FULL;
            end else begin
              moving_nxt = in_item.value;
              pos_nxt    = AW'(count_r);
              count_nxt  = count_r + CW'(1);
              rd_addr_a  = ins_parent;
            end
          end else begin
            if (is_empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
              pos_nxt   = '0;
              rd_addr_a = '0;
              rd_addr_b = AW'(count_r - CW'(1));
            end
          end
        end
      end
      S_UP: begin
        // parent data is on port A
        wr_en = 1'b1;
        if (!up_stop) begin
          wr_data   = rd_data_a;
          pos_nxt   = up_parent;
          rd_addr_a = up_grand;
        end
      end
      S_ROOT: begin
        // root on port A, last entry on port B
        res_removed_nxt = rd_data_a;
        moving_nxt      = rd_data_b;
        rd_addr_a       = AW'(1);
        rd_addr_b       = AW'(2);
      end
      S_DOWN: begin
        wr_en = 1'b1;
        if (!dn_stop) begin
          wr_data   = dn_sel;
          pos_nxt   = dn_cidx;
          rd_addr_a = nx_cl[AW-1:0];
          rd_addr_b = nx_cr[AW-1:0];
        end
      end
      S_WR: begin
        wr_en = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_item_nxt.removed_value = res_removed_r;
          out_item_nxt.status        = res_status_r;
          out_item_nxt.entry_count   = COUNT_OUT_W'(count_r);
          out_valid_nxt              = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    moving_r      <= moving_nxt;
    res_removed_r <= res_removed_nxt;
    res_status_r  <= res_status_nxt;
    out_item_r    <= out_item_nxt;
  end

  // Entry count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // No store write while waiting for an item
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("store write while idle");

  // A remove on an empty heap leaves the count at zero
  a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_item.cmd == CMD_REMOVE && is_empty) |=> (count_r == '0))
    else $error("rejected remove changed the count");

  // Sift-down only runs with at least two entries
  a_down_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DOWN) |-> (count_r >= CW'(2)))
    else $error("sift-down with fewer than two entries");

  // A result appears only out of the done state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside done state");

endmodule

>>> tb/sv/min_heap_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue_tb: self-checking bench for the min-heap queue
// Drives insert and remove commands through the input channel and holds a
// local heap that predicts every result. Each result is compared field by
// field with the oldest prediction. The sender and the receiver both stall
// at random. The run covers remove on empty, value extremes, ties, a fill
// up to capacity with rejected inserts, and a run of removes from the full heap.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_tb
  import mhpq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_DEPTH  = CAPACITY_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned IDLE_PCT    = 31;
  localparam data_t       VAL_MAX     = 32'sh7FFF_FFFF;
  localparam data_t       VAL_MIN     = 32'sh8000_0000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Predicted heap contents and count
  data_t       heap_copy [HEAP_DEPTH];
  int unsigned heap_size = 0;

  out_item_t   pending_heap_results[$];
  int unsigned mismatch_count = 0;
  bit          steady_run = 1'b0;

  min_heap_priority_queue #(
    .CAPACITY (HEAP_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Heap predictor: applies one command to the local heap, returns the result
  // --------------------------------------------------------------------------
  function automatic out_item_t predict_heap_result(in_item_t cmd_item);
    out_item_t   res;
    int unsigned pos;
    int unsigned parent;
    int unsigned child;
    data_t       moving;
    res = '0;
    res.status = ST_DONE;
    if (cmd_item.cmd == CMD_INSERT) begin
      if (heap_size >= HEAP_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // climb while the parent is larger
        pos = heap_size;
        moving = cmd_item.value;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_copy[parent] <= moving) break;
          heap_copy[pos] = heap_copy[parent];
          pos = parent;
        end
        heap_copy[pos] = moving;
        heap_size++;
      end
    end else begin
      if (heap_size == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_value = heap_copy[0];
        heap_size--;
        // last entry goes to the root and sinks; left child wins a tie
        moving = heap_copy[heap_size];
        pos = 0;
        while (1'b1) begin
          child = 2 * pos + 1;
          if (child >= heap_size) break;
          if (child + 1 < heap_size && heap_copy[child] > heap_copy[child + 1]) child++;
          if (moving <= heap_copy[child]) break;
          heap_copy[pos] = heap_copy[child];
          pos = child;
        end
        heap_copy[pos] = moving;
      end
    end
    res.entry_count = heap_size[COUNT_OUT_W-1:0];
    return res;
  endfunction

  // Mostly full-range values, with runs of small ones for ties and the extremes
  function automatic data_t rand_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) return data_t'(int'($urandom_range(16)) - 8);
    if (pick < 40) begin
      case ($urandom_range(3))
        0:       return VAL_MAX;
        1:       return VAL_MIN;
        2:       return data_t'(0);
        default: return data_t'(-1);
      endcase
    end
    return data_t'($urandom);
  endfunction

  function automatic void check_field(string field, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional idle gap, then hold the item until it is taken
  // --------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input data_t value);
    in_item_t next_item;
    next_item.cmd   = cmd;
    next_item.value = value;
    if (!steady_run) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= next_item;
    do @(posedge clk); while (!in_ready);
    pending_heap_results.push_back(predict_heap_result(next_item));
  endtask

  // Sender holds off until every predicted result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_heap_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_heap_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, removed_value %0d status %0d entry_count %0d",
                 $time, out_item.removed_value, out_item.status, out_item.entry_count);
      end else begin
        want = pending_heap_results.pop_front();
        check_field("removed_value", want.removed_value, out_item.removed_value);
        check_field("status", want.status, out_item.status);
        check_field("entry_count", want.entry_count, out_item.entry_count);
      end
    end
  end

  // Receiver stalls at random outside steady stretches
  always @(posedge clk) begin
    out_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog on cycles where no item moves on either channel
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("[min_heap_priority_queue] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Remove on an empty heap, value field ignored
  task automatic test_remove_on_empty();
    send_item(CMD_REMOVE, VAL_MAX);
    send_item(CMD_REMOVE, VAL_MIN);
  endtask

  // Extremes, duplicates for tie handling, then remove past empty
  task automatic test_value_extremes();
    send_item(CMD_INSERT, VAL_MAX);
    send_item(CMD_INSERT, VAL_MIN);
    send_item(CMD_INSERT, data_t'(0));
    send_item(CMD_INSERT, data_t'(-1));
    send_item(CMD_INSERT, data_t'(1));
    send_item(CMD_INSERT, VAL_MIN);
    send_item(CMD_INSERT, data_t'(5));
    send_item(CMD_INSERT, data_t'(5));
    send_item(CMD_INSERT, data_t'(5));
    repeat (10) send_item(CMD_REMOVE, data_t'($urandom));
  endtask

  // Balanced mix around an almost empty heap
  task automatic test_random_mix();
    repeat (30) send_item(logic'($urandom_range(1)), rand_value());
  endtask

  // Grow to capacity, then inserts on a full heap are rejected
  task automatic test_fill_to_capacity();
    while (heap_size < HEAP_DEPTH)
      send_item(($urandom_range(99) < 97) ? CMD_INSERT : CMD_REMOVE, rand_value());
    repeat (3) send_item(CMD_INSERT, rand_value());
    send_item(CMD_REMOVE, rand_value());
    send_item(CMD_INSERT, VAL_MAX);
    send_item(CMD_INSERT, VAL_MIN);
    wait_results_drained();
  endtask

  // Mostly removes from a full heap, deep sift-down paths
  task automatic test_drain_burst();
    repeat (50)
      send_item(($urandom_range(99) < 90) ? CMD_REMOVE : CMD_INSERT, rand_value());
  endtask

  // Back-to-back items with no stalls on either side
  task automatic test_steady_stream();
    steady_run = 1'b1;
    repeat (60) send_item(($urandom_range(99) < 60) ? CMD_INSERT : CMD_REMOVE, rand_value());
    steady_run = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_remove_on_empty();
    test_value_extremes();
    wait_results_drained();
    test_random_mix();
    test_fill_to_capacity();
    test_drain_burst();
    test_steady_stream();

    // let the last results through, plus a short tail
    wait_results_drained();
    repeat (40) @(posedge clk);
    if (pending_heap_results.size() != 0) begin
      mismatch_count++;
      $display("%0t ns: %0d results never arrived", $time, pending_heap_results.size());
    end

    if (mismatch_count == 0) begin
      $display("[min_heap_priority_queue] OK");
    end else begin
      $display("[min_heap_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
